>>> rtl/rotating_polygon_vertex_generator_core_macros.svh
// Assertion helpers used by the core RTL.
`ifndef ROTATING_POLYGON_VERTEX_GENERATOR_CORE_MACROS_SVH
`define ROTATING_POLYGON_VERTEX_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RPVG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPVG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rpvg_pkg.sv
`timescale 1ns / 1ps

package rpvg_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_SIDE_COS    = 3'd0;
    localparam logic [2:0] REG_SIDE_SIN    = 3'd1;
    localparam logic [2:0] REG_SHAPE_COS   = 3'd2;
    localparam logic [2:0] REG_SHAPE_SIN   = 3'd3;
    localparam logic [2:0] REG_SIDE_COUNT  = 3'd4;
    localparam logic [2:0] REG_SHAPE_COUNT = 3'd5;
    localparam logic [2:0] REG_ORIGIN_X    = 3'd6;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd7;

    // Microprogram entry points
    localparam logic [4:0] UA_IDLE   = 5'd0;
    localparam logic [4:0] UA_DECODE = 5'd1;
    localparam logic [4:0] UA_VERTEX = 5'd2;
    localparam logic [4:0] UA_SHAPE  = 5'd9;

    typedef enum logic [1:0] {ASEL_PX, ASEL_PY, ASEL_TX, ASEL_TY} a_sel_t;

    typedef enum logic [2:0] {
        BSEL_ASPECT,
        BSEL_SIDE_COS,
        BSEL_SIDE_SIN,
        BSEL_SHAPE_COS,
        BSEL_SHAPE_SIN,
        BSEL_SCALE
    } b_sel_t;

    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {TX_HOLD, TX_RND_ACC, TX_RND_PROD} tx_op_t;
    typedef enum logic {TY_HOLD, TY_RND_ACC} ty_op_t;
    typedef enum logic [1:0] {PT_HOLD, PT_START, PT_SIDE, PT_SHAPE} pt_op_t;

    typedef enum logic [2:0] {
        ACT_NOP,
        ACT_WAIT,
        ACT_DECODE,
        ACT_SCREEN,
        ACT_SIDE,
        ACT_SHAPE
    } act_t;

    typedef struct packed {
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        logic       mul_en;
        acc_op_t    acc_op;
        tx_op_t     tx_op;
        ty_op_t     ty_op;
        act_t       act;
        logic [4:0] next_addr;
    } uword_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        logic    mul_en;
        acc_op_t acc_op;
        tx_op_t  tx_op;
        ty_op_t  ty_op;
        pt_op_t  pt_op;
    } dp_ctrl_t;

    typedef struct packed {
        logic signed [15:0] side_cos;
        logic signed [15:0] side_sin;
        logic signed [15:0] shape_cos;
        logic signed [15:0] shape_sin;
        logic [5:0]         side_count;
        logic [5:0]         shape_count;
        logic [8:0]         origin_x;
        logic [8:0]         origin_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        side_cos:    16'sd16384,
        side_sin:    16'sd28378,
        shape_cos:   16'sd32643,
        shape_sin:   16'sd2856,
        side_count:  6'd6,
        shape_count: 6'd40,
        origin_x:    9'd160,
        origin_y:    9'd100
    };

    // Microprogram. The multiplier result is registered, so
    // accumulate steps consume the product issued in the step before.
    function automatic uword_t ucode_rom(input logic [4:0] addr);
        uword_t w;
        w = '{ASEL_PX, BSEL_ASPECT, 1'b0, ACC_HOLD, TX_HOLD, TY_HOLD, ACT_NOP, UA_IDLE};
        unique case (addr)
            5'd0:  w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_WAIT,   UA_IDLE};
            5'd1:  w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_DECODE, UA_VERTEX};
            5'd2:  w = '{ASEL_PX, BSEL_ASPECT,    1'b1, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd3};
            5'd3:  w = '{ASEL_PX, BSEL_SIDE_COS,  1'b1, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_SCREEN, 5'd4};
            5'd4:  w = '{ASEL_PY, BSEL_SIDE_SIN,  1'b1, ACC_LOAD, TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd5};
            5'd5:  w = '{ASEL_PX, BSEL_SIDE_SIN,  1'b1, ACC_SUB,  TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd6};
            5'd6:  w = '{ASEL_PY, BSEL_SIDE_COS,  1'b1, ACC_LOAD, TX_RND_ACC,  TY_HOLD,
                         ACT_NOP,    5'd7};
            5'd7:  w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_ADD,  TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd8};
            5'd8:  w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_SIDE,   UA_SHAPE};
            5'd9:  w = '{ASEL_PX, BSEL_SHAPE_COS, 1'b1, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd10};
            5'd10: w = '{ASEL_PY, BSEL_SHAPE_SIN, 1'b1, ACC_LOAD, TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd11};
            5'd11: w = '{ASEL_PX, BSEL_SHAPE_SIN, 1'b1, ACC_SUB,  TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd12};
            5'd12: w = '{ASEL_PY, BSEL_SHAPE_COS, 1'b1, ACC_LOAD, TX_RND_ACC,  TY_HOLD,
                         ACT_NOP,    5'd13};
            5'd13: w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_ADD,  TX_HOLD,     TY_HOLD,
                         ACT_NOP,    5'd14};
            5'd14: w = '{ASEL_TX, BSEL_SCALE,     1'b1, ACC_HOLD, TX_HOLD,     TY_RND_ACC,
                         ACT_NOP,    5'd15};
            5'd15: w = '{ASEL_TY, BSEL_SCALE,     1'b1, ACC_HOLD, TX_RND_PROD, TY_HOLD,
                         ACT_NOP,    5'd16};
            5'd16: w = '{ASEL_PX, BSEL_ASPECT,    1'b0, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_SHAPE,  UA_IDLE};
            default: w = '{ASEL_PX, BSEL_ASPECT,  1'b0, ACC_HOLD, TX_HOLD,     TY_HOLD,
                         ACT_NOP,    UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/rotating_polygon_vertex_generator_core.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// request   in_valid / in_ready        restart, stop
// result    out_valid / out_ready      vtx_x, vtx_y, move_first,
//                                      vertex_valid, figure_done, aborted
// config    cfg_we (no wait)           cfg_index, cfg_wdata
//
// The figure is computed by one shared 26x18 multiplier stepped by the
// microprogram: at most one product per step, four per rotation plus one
// for the screen x map and two for the shape scale.
// Reset: configuration returns to its defaults, no figure is active and the
// point sits at (95,0). A held result stalls the sequencer only at the step
// that emits the next result; a new request is taken whenever the sequencer
// is back at its idle step.
`include "rotating_polygon_vertex_generator_core_macros.svh"

module rotating_polygon_vertex_generator_core import rpvg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              restart,
    input  logic              stop,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [9:0] vtx_x,
    output logic signed [9:0] vtx_y,
    output logic              move_first,
    output logic              vertex_valid,
    output logic              figure_done,
    output logic              aborted,
    // configuration port
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);

    // Sequencer state
    logic [4:0] upc_reg, upc_next;
    uword_t     uw;

    // Request latched at accept
    logic restart_reg;
    logic stop_reg;

    // Figure progress
    logic [5:0] vi_reg;
    logic [5:0] si_reg;
    logic       active_reg;

    cfg_t cfg_reg;

    // Screen coordinates captured mid-vertex
    logic signed [9:0] sx_hold_reg;
    logic signed [9:0] sy_hold_reg;

    // Result register
    logic              out_valid_reg;
    logic signed [9:0] vtx_x_reg;
    logic signed [9:0] vtx_y_reg;
    logic              move_first_reg;
    logic              vertex_valid_reg;
    logic              figure_done_reg;
    logic              aborted_reg;

    // Decision terms
    logic     accept;
    logic     active_after;
    logic     vertex_go;
    logic     shape_end;
    logic     figure_end;
    logic     emit;
    logic     stall;
    dp_ctrl_t dp_ctrl;

    logic signed [9:0] scr_x;
    logic signed [9:0] scr_y;

    assign uw       = ucode_rom(upc_reg);
    assign in_ready = (upc_reg == UA_IDLE);
    assign accept   = in_valid && in_ready;

    // A stop wins over restart; a restart with a zero count leaves no figure.
    assign active_after = stop_reg ? 1'b0 :
                          restart_reg ? ((cfg_reg.side_count != '0) &&
                                         (cfg_reg.shape_count != '0)) :
                          active_reg;
    assign vertex_go  = active_after;
    assign shape_end  = (vi_reg >= cfg_reg.side_count);
    assign figure_end = shape_end && ({1'b0, si_reg} + 7'd1 >= {1'b0, cfg_reg.shape_count});

    // Emit a result at decode when no vertex follows, and at the side write-back.
    assign emit  = ((uw.act == ACT_DECODE) && !vertex_go) || (uw.act == ACT_SIDE);
    assign stall = emit && out_valid_reg && !out_ready;

    // Next step
    always_comb
    begin
        unique case (uw.act)
            ACT_WAIT:   upc_next = accept ? UA_DECODE : UA_IDLE;
            ACT_DECODE: upc_next = stall ? upc_reg : (vertex_go ? uw.next_addr : UA_IDLE);
            ACT_SIDE:   upc_next = stall ? upc_reg :
                                   ((shape_end && !figure_end) ? uw.next_addr : UA_IDLE);
            default:    upc_next = uw.next_addr;
        endcase
    end

    // Datapath control from the control word; hold everything while stalled.
    always_comb
    begin
        dp_ctrl.a_sel  = uw.a_sel;
        dp_ctrl.b_sel  = uw.b_sel;
        dp_ctrl.mul_en = uw.mul_en && !stall;
        dp_ctrl.acc_op = stall ? ACC_HOLD : uw.acc_op;
        dp_ctrl.tx_op  = stall ? TX_HOLD : uw.tx_op;
        dp_ctrl.ty_op  = stall ? TY_HOLD : uw.ty_op;
        unique case (uw.act)
            ACT_DECODE: dp_ctrl.pt_op = (restart_reg && !stop_reg && !stall) ? PT_START
                                                                             : PT_HOLD;
            ACT_SIDE:   dp_ctrl.pt_op = stall ? PT_HOLD : PT_SIDE;
            ACT_SHAPE:  dp_ctrl.pt_op = PT_SHAPE;
            default:    dp_ctrl.pt_op = PT_HOLD;
        endcase
    end

    rpvg_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dp_ctrl),
        .cfg   (cfg_reg),
        .scr_x (scr_x),
        .scr_y (scr_y)
    );

    // Sequencer, request latch, figure progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg     <= UA_IDLE;
            restart_reg <= 1'b0;
            stop_reg    <= 1'b0;
            vi_reg      <= '0;
            si_reg      <= '0;
            active_reg  <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (accept)
            begin
                restart_reg <= restart;
                stop_reg    <= stop;
            end
            if ((uw.act == ACT_DECODE) && !stall)
            begin
                active_reg <= active_after;
                if (restart_reg && !stop_reg)
                begin
                    vi_reg <= '0;
                    si_reg <= '0;
                end
            end
            if ((uw.act == ACT_SIDE) && !stall)
            begin
                if (shape_end)
                begin
                    vi_reg <= '0;
                    if (figure_end)
                        active_reg <= 1'b0;
                    else
                        si_reg <= si_reg + 6'd1;
                end
                else
                begin
                    vi_reg <= vi_reg + 6'd1;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIDE_COS:    cfg_reg.side_cos    <= cfg_wdata;
                REG_SIDE_SIN:    cfg_reg.side_sin    <= cfg_wdata;
                REG_SHAPE_COS:   cfg_reg.shape_cos   <= cfg_wdata;
                REG_SHAPE_SIN:   cfg_reg.shape_sin   <= cfg_wdata;
                REG_SIDE_COUNT:  cfg_reg.side_count  <= cfg_wdata[5:0];
                REG_SHAPE_COUNT: cfg_reg.shape_count <= cfg_wdata[5:0];
                REG_ORIGIN_X:    cfg_reg.origin_x    <= cfg_wdata[8:0];
                REG_ORIGIN_Y:    cfg_reg.origin_y    <= cfg_wdata[8:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Capture screen coordinates while the multiplier moves on to rotation.
    always_ff @(posedge clk)
    begin
        if (uw.act == ACT_SCREEN)
        begin
            sx_hold_reg <= scr_x;
            sy_hold_reg <= scr_y;
        end
    end

    // Result register: load on emit, drop valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit && !stall)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit && !stall)
        begin
            if (uw.act == ACT_SIDE)
            begin
                vtx_x_reg        <= sx_hold_reg;
                vtx_y_reg        <= sy_hold_reg;
                move_first_reg   <= (vi_reg == '0);
                vertex_valid_reg <= 1'b1;
                figure_done_reg  <= figure_end;
                aborted_reg      <= 1'b0;
            end
            else
            begin
                vtx_x_reg        <= '0;
                vtx_y_reg        <= '0;
                move_first_reg   <= 1'b0;
                vertex_valid_reg <= 1'b0;
                figure_done_reg  <= 1'b1;
                aborted_reg      <= stop_reg && active_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign vtx_x        = vtx_x_reg;
    assign vtx_y        = vtx_y_reg;
    assign move_first   = move_first_reg;
    assign vertex_valid = vertex_valid_reg;
    assign figure_done  = figure_done_reg;
    assign aborted      = aborted_reg;

    `RPVG_ASSERT_NEXT(a_accept_decodes, accept, upc_reg == UA_DECODE, "accept did not decode")
    `RPVG_ASSERT_NOW(a_shape_needs_figure, upc_reg >= UA_SHAPE, active_reg, "shape step idle")
    `RPVG_ASSERT_NOW(a_empty_is_done, out_valid && !vertex_valid, figure_done, "empty not done")
    `RPVG_ASSERT_NOW(a_vertex_not_aborted, out_valid && vertex_valid, !aborted, "vertex aborted")

endmodule

>>> rtl/rpvg_datapath.sv
`timescale 1ns / 1ps

// Point registers, shared multiplier, accumulator and screen mapping.
module rpvg_datapath import rpvg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    input  cfg_t               cfg,
    output logic signed [9:0]  scr_x,
    output logic signed [9:0]  scr_y
);

    localparam logic signed [23:0] START_X    = 24'sd6225920;  // 95 in Q8.16
    localparam logic signed [17:0] ASPECT_Q16 = 18'sd76022;
    localparam logic signed [17:0] SCALE_Q15  = 18'sd31130;

    function automatic logic signed [29:0] rnd15(input logic signed [44:0] v);
        logic signed [44:0] t;
        t = v + 45'sd16384;
        return t[44:15];
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        logic signed [23:0] r;
        if (v > 30'sd8388607)
            r = 24'sh7fffff;
        else if (v < -30'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

    function automatic logic signed [9:0] sat10(input logic signed [15:0] v);
        logic signed [9:0] r;
        if (v > 16'sd511)
            r = 10'sd511;
        else if (v < -16'sd512)
            r = -10'sd512;
        else
            r = v[9:0];
        return r;
    endfunction

    logic signed [23:0] px_reg, px_next;
    logic signed [23:0] py_reg, py_next;
    logic signed [25:0] tx_reg, tx_next;
    logic signed [25:0] ty_reg, ty_next;
    logic signed [43:0] prod_reg, prod_next;
    logic signed [44:0] acc_reg, acc_next;

    logic signed [25:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [44:0] prod_ext;
    logic signed [29:0] rnd_acc;
    logic signed [29:0] rnd_prod;
    logic signed [29:0] tx_ext;

    logic signed [44:0] sx_sum;
    logic signed [44:0] sx_adj;
    logic signed [26:0] sy_sum;
    logic signed [26:0] sy_adj;

    assign prod_ext = {prod_reg[43], prod_reg};
    assign rnd_acc  = rnd15(acc_reg);
    assign rnd_prod = rnd15(prod_ext);
    assign tx_ext   = {{4{tx_reg[25]}}, tx_reg};

    always_comb
    begin
        case (ctrl.a_sel)
            ASEL_PX: mul_a = {{2{px_reg[23]}}, px_reg};
            ASEL_PY: mul_a = {{2{py_reg[23]}}, py_reg};
            ASEL_TX: mul_a = tx_reg;
            ASEL_TY: mul_a = ty_reg;
            default: mul_a = '0;
        endcase
        case (ctrl.b_sel)
            BSEL_ASPECT:    mul_b = ASPECT_Q16;
            BSEL_SIDE_COS:  mul_b = {{2{cfg.side_cos[15]}}, cfg.side_cos};
            BSEL_SIDE_SIN:  mul_b = {{2{cfg.side_sin[15]}}, cfg.side_sin};
            BSEL_SHAPE_COS: mul_b = {{2{cfg.shape_cos[15]}}, cfg.shape_cos};
            BSEL_SHAPE_SIN: mul_b = {{2{cfg.shape_sin[15]}}, cfg.shape_sin};
            BSEL_SCALE:     mul_b = SCALE_Q15;
            default:        mul_b = '0;
        endcase
    end

    always_comb
    begin
        prod_next = ctrl.mul_en ? 44'(mul_a * mul_b) : prod_reg;

        case (ctrl.acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase

        case (ctrl.tx_op)
            TX_RND_ACC:  tx_next = rnd_acc[25:0];
            TX_RND_PROD: tx_next = rnd_prod[25:0];
            default:     tx_next = tx_reg;
        endcase

        ty_next = (ctrl.ty_op == TY_RND_ACC) ? rnd_acc[25:0] : ty_reg;

        case (ctrl.pt_op)
            PT_START:
            begin
                px_next = START_X;
                py_next = '0;
            end
            PT_SIDE:
            begin
                px_next = sat24(tx_ext);
                py_next = sat24(rnd_acc);
            end
            PT_SHAPE:
            begin
                px_next = sat24(tx_ext);
                py_next = sat24(rnd_prod);
            end
            default:
            begin
                px_next = px_reg;
                py_next = py_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg <= START_X;
            py_reg <= '0;
        end
        else
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    // Screen map: prod holds x*aspect here; truncate toward zero, then clamp.
    always_comb
    begin
        sx_sum = prod_ext + $signed({4'b0, cfg.origin_x, 32'b0});
        sx_adj = sx_sum + (sx_sum[44] ? 45'sd4294967295 : 45'sd0);
        sy_sum = {{3{py_reg[23]}}, py_reg} + $signed({2'b0, cfg.origin_y, 16'b0});
        sy_adj = sy_sum + (sy_sum[26] ? 27'sd65535 : 27'sd0);
        scr_x  = sat10({{3{sx_adj[44]}}, sx_adj[44:32]});
        scr_y  = sat10({{5{sy_adj[26]}}, sy_adj[26:16]});
    end

endmodule

>>> sim/rotating_polygon_vertex_generator_core_test.sv
`timescale 1ns / 1ps

module rotating_polygon_vertex_generator_core_test;
    import rpvg_pkg::*;

    // Fixed-point constants of the figure: start point, shape shrink, screen aspect.
    localparam longint START_X_Q16   = 95 * 65536;
    localparam longint SCALE_Q15     = 31130;
    localparam longint ASPECT_Q16    = 76022;
    localparam longint PT_MAX        = 8388607;
    localparam longint PT_MIN        = -8388608;
    localparam longint SCR_MAX       = 511;
    localparam longint SCR_MIN       = -512;
    // Leave margin after the last result for a vertex that closes a shape to finish.
    localparam int     SETTLE_CYCLES = 40;
    localparam int     RANDOM_ITEMS  = 600;
    localparam real    PI            = 3.14159265358979;

    typedef struct packed {
        logic signed [9:0] vtx_x;
        logic signed [9:0] vtx_y;
        logic              move_first;
        logic              vertex_valid;
        logic              figure_done;
        logic              aborted;
    } vertex_t;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_TRICKLE} rx_mode_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  index;
        logic [15:0] data;
        bit          restart;
        bit          stop;
        bit          typed;
        vertex_t     want;
    } plan_row_t;

    // Results that can be read straight off the spec.
    localparam vertex_t IDLE_RESULT  = '{10'sd0, 10'sd0, 1'b0, 1'b0, 1'b1, 1'b0};
    localparam vertex_t ABORT_RESULT = '{10'sd0, 10'sd0, 1'b0, 1'b0, 1'b1, 1'b1};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              restart = 1'b0;
    logic              stop = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [9:0] vtx_x;
    logic signed [9:0] vtx_y;
    logic              move_first;
    logic              vertex_valid;
    logic              figure_done;
    logic              aborted;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = REG_SIDE_COS;
    logic [15:0]       cfg_wdata = 16'd0;

    rotating_polygon_vertex_generator_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .stop         (stop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .vtx_x        (vtx_x),
        .vtx_y        (vtx_y),
        .move_first   (move_first),
        .vertex_valid (vertex_valid),
        .figure_done  (figure_done),
        .aborted      (aborted),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: configuration, point and counters.
    // ------------------------------------------------------------------
    cfg_t       shadow_cfg = CFG_RESET;
    longint     pt_x = START_X_Q16;
    longint     pt_y = 0;
    logic [5:0] vtx_idx = 6'd0;
    logic [5:0] shp_idx = 6'd0;
    bit         fig_on = 1'b0;

    vertex_t    pending_vertices[$];
    int         mismatch_count = 0;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round half up at bit 15: add half, then floor.
    function automatic longint round_q15(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint trunc_shift(input longint v, input int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    // Rotate the point by (c, s); on a shape step also shrink it by 0.95 before saturating.
    function automatic void turn_point(input logic signed [15:0] c,
                                       input logic signed [15:0] s, input bit shrink);
        longint cl;
        longint sl;
        longint nx;
        longint ny;
        cl = c;
        sl = s;
        nx = round_q15(pt_x * cl - pt_y * sl);
        ny = round_q15(pt_x * sl + pt_y * cl);
        if (shrink)
        begin
            nx = round_q15(nx * SCALE_Q15);
            ny = round_q15(ny * SCALE_Q15);
        end
        pt_x = clamp(nx, PT_MIN, PT_MAX);
        pt_y = clamp(ny, PT_MIN, PT_MAX);
    endfunction

    // Work out the result of one request and advance the shadow state.
    function automatic vertex_t next_vertex(input bit rs, input bit sp);
        vertex_t v;
        longint  sx;
        longint  sy;
        v = '0;
        // Stop wins over restart; it only counts as an abort if a figure was running.
        if (sp)
        begin
            v.aborted     = fig_on;
            v.figure_done = 1'b1;
            fig_on        = 1'b0;
            return v;
        end
        if (rs)
        begin
            pt_x    = START_X_Q16;
            pt_y    = 0;
            vtx_idx = 6'd0;
            shp_idx = 6'd0;
            fig_on  = (shadow_cfg.side_count != 6'd0) && (shadow_cfg.shape_count != 6'd0);
        end
        if (!fig_on)
        begin
            v.figure_done = 1'b1;
            return v;
        end
        sx = trunc_shift(pt_x * ASPECT_Q16 + (longint'(shadow_cfg.origin_x) << 32), 32);
        sy = trunc_shift(pt_y + (longint'(shadow_cfg.origin_y) << 16), 16);
        sx = clamp(sx, SCR_MIN, SCR_MAX);
        sy = clamp(sy, SCR_MIN, SCR_MAX);
        v.vtx_x        = sx[9:0];
        v.vtx_y        = sy[9:0];
        v.move_first   = (vtx_idx == 6'd0);
        v.vertex_valid = 1'b1;
        turn_point(shadow_cfg.side_cos, shadow_cfg.side_sin, 1'b0);
        // Counts may change mid-figure, hence the >= tests.
        if (vtx_idx >= shadow_cfg.side_count)
        begin
            vtx_idx = 6'd0;
            if (shp_idx + 1 >= shadow_cfg.shape_count)
            begin
                fig_on        = 1'b0;
                v.figure_done = 1'b1;
            end
            else
            begin
                shp_idx = shp_idx + 6'd1;
                turn_point(shadow_cfg.shape_cos, shadow_cfg.shape_sin, 1'b1);
            end
        end
        else
            vtx_idx = vtx_idx + 6'd1;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker.
    // ------------------------------------------------------------------
    rx_mode_t   rx_mode = RX_STREAM;
    logic [9:0] rx_tick = 10'd0;

    // Switch the stall regime whenever the low byte of the tick counter wraps: free flow,
    // coin flip, or a trickle that raises ready only when the low four tick bits are zero.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 10'd1;
        if (rx_tick[7:0] == 8'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 2));
        case (rx_mode)
            RX_STREAM: out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            default:   out_ready <= (rx_tick[3:0] == 4'd0);
        endcase
    end

    task automatic report_mismatch(input string what, input logic [9:0] got,
                                   input logic [9:0] want);
        if (mismatch_count < 50)
            $display("ERROR at %0t: %s got %0d expected %0d", $time, what,
                     $signed(got), $signed(want));
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compare every accepted result with the oldest expected vertex.
    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_vertices.size() == 0)
                report_mismatch("unexpected result, vtx_x", vtx_x, 10'd0);
            else
            begin
                want = pending_vertices.pop_front();
                check_field("vtx_x", vtx_x, want.vtx_x);
                check_field("vtx_y", vtx_y, want.vtx_y);
                check_field("move_first", 10'(move_first), 10'(want.move_first));
                check_field("vertex_valid", 10'(vertex_valid), 10'(want.vertex_valid));
                check_field("figure_done", 10'(figure_done), 10'(want.figure_done));
                check_field("aborted", 10'(aborted), 10'(want.aborted));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side.
    // ------------------------------------------------------------------
    int burst_left = 0;

    // Drop valid, wait for every expected result, then let the sequencer finish
    // the rotation that trails the last result.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register and mirror it, masked to the register width.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SIDE_COS:    shadow_cfg.side_cos    = data;
            REG_SIDE_SIN:    shadow_cfg.side_sin    = data;
            REG_SHAPE_COS:   shadow_cfg.shape_cos   = data;
            REG_SHAPE_SIN:   shadow_cfg.shape_sin   = data;
            REG_SIDE_COUNT:  shadow_cfg.side_count  = data[5:0];
            REG_SHAPE_COUNT: shadow_cfg.shape_count = data[5:0];
            REG_ORIGIN_X:    shadow_cfg.origin_x    = data[8:0];
            default:         shadow_cfg.origin_y    = data[8:0];
        endcase
        @(posedge clk);
    endtask

    // Send one request in bursts with random gaps; hold valid across back-to-back
    // requests so it is never lowered and raised in the same step.
    task automatic send_request(input bit rs, input bit sp, input bit typed,
                                input vertex_t want);
        int      gap;
        vertex_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        restart  <= rs;
        stop     <= sp;
        predicted = next_vertex(rs, sp);
        pending_vertices.push_back(typed ? want : predicted);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // ------------------------------------------------------------------
    // Directed table.
    // ------------------------------------------------------------------
    plan_row_t plan[$];

    function automatic plan_row_t step_row(input bit rs, input bit sp);
        plan_row_t r;
        r = '{ROW_REQUEST, REG_SIDE_COS, 16'd0, rs, sp, 1'b0, IDLE_RESULT};
        return r;
    endfunction

    function automatic plan_row_t check_row(input bit rs, input bit sp, input vertex_t want);
        plan_row_t r;
        r = '{ROW_REQUEST, REG_SIDE_COS, 16'd0, rs, sp, 1'b1, want};
        return r;
    endfunction

    function automatic plan_row_t write_row(input logic [2:0] idx, input logic [15:0] data);
        plan_row_t r;
        r = '{ROW_WRITE, idx, data, 1'b0, 1'b0, 1'b0, IDLE_RESULT};
        return r;
    endfunction

    task automatic build_plan();
        // Idle after reset, and a stop with nothing running is no abort.
        plan.push_back(check_row(1'b0, 1'b0, IDLE_RESULT));
        plan.push_back(check_row(1'b0, 1'b1, IDLE_RESULT));
        // Start point (95,0) at the default center: x = 110 + 160, y = 100.
        plan.push_back(check_row(1'b1, 1'b0, '{10'sd270, 10'sd100, 1'b1, 1'b1, 1'b0, 1'b0}));
        plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(step_row(1'b0, 1'b0));
        // Stop together with restart: stop wins and aborts the running figure.
        plan.push_back(check_row(1'b1, 1'b1, ABORT_RESULT));
        plan.push_back(check_row(1'b0, 1'b0, IDLE_RESULT));
        // Zero side count, then zero shape count: restart starts nothing.
        plan.push_back(write_row(REG_SIDE_COUNT, 16'd0));
        plan.push_back(check_row(1'b1, 1'b0, IDLE_RESULT));
        plan.push_back(write_row(REG_SIDE_COUNT, 16'd1));
        plan.push_back(write_row(REG_SHAPE_COUNT, 16'd0));
        plan.push_back(check_row(1'b1, 1'b0, IDLE_RESULT));
        // Two shapes of two vertices: the fourth vertex closes the figure.
        plan.push_back(write_row(REG_SHAPE_COUNT, 16'd2));
        plan.push_back(check_row(1'b1, 1'b0, '{10'sd270, 10'sd100, 1'b1, 1'b1, 1'b0, 1'b0}));
        plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(check_row(1'b0, 1'b0, IDLE_RESULT));
        // Largest counts and centers: the screen point saturates at 511.
        plan.push_back(write_row(REG_SIDE_COUNT, 16'd63));
        plan.push_back(write_row(REG_SHAPE_COUNT, 16'd63));
        plan.push_back(write_row(REG_ORIGIN_X, 16'd511));
        plan.push_back(write_row(REG_ORIGIN_Y, 16'd511));
        plan.push_back(check_row(1'b1, 1'b0, '{10'sd511, 10'sd511, 1'b1, 1'b1, 1'b0, 1'b0}));
        plan.push_back(write_row(REG_ORIGIN_X, 16'd0));
        plan.push_back(write_row(REG_ORIGIN_Y, 16'd0));
        plan.push_back(step_row(1'b0, 1'b0));
        // Drop the side count under the running vertex index mid-figure.
        plan.push_back(write_row(REG_SIDE_COUNT, 16'd0));
        plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(step_row(1'b0, 1'b0));
        // Extreme coefficients grow the point until it saturates.
        plan.push_back(write_row(REG_SIDE_COS, 16'h8000));
        plan.push_back(write_row(REG_SIDE_SIN, 16'h8000));
        plan.push_back(write_row(REG_SHAPE_COS, 16'h7FFF));
        plan.push_back(write_row(REG_SHAPE_SIN, 16'h7FFF));
        plan.push_back(write_row(REG_SIDE_COUNT, 16'd5));
        plan.push_back(check_row(1'b1, 1'b0, '{10'sd110, 10'sd0, 1'b1, 1'b1, 1'b0, 1'b0}));
        repeat (5) plan.push_back(step_row(1'b0, 1'b0));
        plan.push_back(check_row(1'b0, 1'b1, ABORT_RESULT));
    endtask

    // ------------------------------------------------------------------
    // Random setups.
    // ------------------------------------------------------------------
    function automatic logic [15:0] to_q15(input real r);
        int k;
        k = $rtoi(r * 32767.0);
        return k[15:0];
    endfunction

    function automatic logic [5:0] pick_count(input int small_max);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 6'd0;
        if (r == 1)
            return 6'd63;
        if (r == 2)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, small_max));
    endfunction

    function automatic logic [8:0] pick_center();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 9'd0;
        if (r == 1)
            return 9'd511;
        return 9'($urandom_range(0, 511));
    endfunction

    // Write a pair of coefficients: mostly a true rotation, sometimes raw values.
    task automatic write_angle(input logic [2:0] cos_idx, input logic [2:0] sin_idx);
        real ang;
        ang = $urandom_range(0, 3599) * PI / 1800.0;
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(cos_idx, 16'($urandom));
            write_reg(sin_idx, 16'($urandom));
        end
        else
        begin
            write_reg(cos_idx, to_q15($cos(ang)));
            write_reg(sin_idx, to_q15($sin(ang)));
        end
    endtask

    // Fill the unused upper bits with noise; the block keeps only the field.
    task automatic pick_setup();
        wait_until_drained();
        write_angle(REG_SIDE_COS, REG_SIDE_SIN);
        write_angle(REG_SHAPE_COS, REG_SHAPE_SIN);
        write_reg(REG_SIDE_COUNT, {10'($urandom), pick_count(6)});
        write_reg(REG_SHAPE_COUNT, {10'($urandom), pick_count(5)});
        write_reg(REG_ORIGIN_X, {7'($urandom), pick_center()});
        write_reg(REG_ORIGIN_Y, {7'($urandom), pick_center()});
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        int  sent;
        int  phase_len;
        int  pick;
        bit  rs;
        bit  sp;
        build_plan();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_until_drained();
                write_reg(plan[i].index, plan[i].data);
            end
            else
                send_request(plan[i].restart, plan[i].stop, plan[i].typed, plan[i].want);
        end

        // Random phases: a fresh setup, then mostly complete figures with some noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick_setup();
            phase_len = $urandom_range(30, 70);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                rs = 1'b0;
                sp = 1'b0;
                if (!fig_on && pick < 80)
                    rs = 1'b1;
                else if (pick >= 97)
                begin
                    rs = 1'b1;
                    sp = 1'b1;
                end
                else if (pick >= 94)
                    sp = 1'b1;
                else if (pick >= 90)
                    rs = 1'b1;
                send_request(rs, sp, 1'b0, IDLE_RESULT);
                sent++;
                // Now and then hold the request side until the block has emptied.
                if ($urandom_range(0, 59) == 0)
                    wait_until_drained();
            end
        end

        wait_until_drained();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
